FILE: rtl/tac_pkg.sv
// Package of the tiny accumulator processor: opcodes, controller states,
// and the command and status structs between controller and datapath.
// No dependencies; used by every module of the block but the checker.
package tac_pkg;

  // Fixed field widths of the stream payloads.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;

  // Instruction opcodes. OP_HALT and anything above OP_JZ halt the machine.
  localparam logic [7:0] OP_LDA   = 8'd0;
  localparam logic [7:0] OP_STA   = 8'd1;
  localparam logic [7:0] OP_ADD   = 8'd2;
  localparam logic [7:0] OP_PRINT = 8'd3;
  localparam logic [7:0] OP_HALT  = 8'd4;
  localparam logic [7:0] OP_EQ    = 8'd5;
  localparam logic [7:0] OP_JMP   = 8'd6;
  localparam logic [7:0] OP_JZ    = 8'd7;

  // Instructions are two bytes long.
  localparam logic [7:0] PC_STEP = 8'd2;

  // Input command codes carried on in_tuser.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_RD_ARG  = 5'b00010,
    ST_RD_DATA = 5'b00100,
    ST_EXEC    = 5'b01000,
    ST_DONE    = 5'b10000
  } state_t;

  // Source of the memory read address.
  typedef enum logic [1:0] {
    ASEL_PC   = 2'd0,
    ASEL_ARG  = 2'd1,
    ASEL_OPND = 2'd2
  } addr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      mem_rd;
    addr_sel_t addr_sel;
    logic      ld_wr;
    logic      sta_wr;
    logic      cap_op;
    logic      cap_arg;
    logic      exec;
    logic      publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic halted;
    logic op_is_sta;
  } stat_t;

endpackage

FILE: rtl/tiny_accumulator_cpu.sv
// Top level of the tiny accumulator processor: stream ports, controller and
// datapath. Depends on tac_pkg, tac_ctrl and tac_dpath.
//
//   Channel  Direction  tdata (low bit up)                       tuser
//   in_      slave      load_address[7:0], load_data[15:8]        command
//   out_     master     print_value[7:0], halted[8],              print_valid
//                       program_counter[16:9], accumulator[24:17]
//
// A step item passes the idle state, where the opcode read at PC overlaps,
// then the operand read, the data read (or STA write) and the execute state,
// all reads on the single synchronous read port of the unified memory.
// A load item and a step while halted pass from idle through the done state.
// Reset (rst_n low, synchronous) clears PC, accumulator, halt flag and the
// result valid flag; memory contents and the result payload are not cleared.
// A result waits in the output register; the next item is taken while it
// waits, and execute or done stalls only if the previous result is still not taken.
module tiny_accumulator_cpu #(
  parameter int unsigned MEM_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // load_address[7:0], load_data[15:8]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // print_value[7:0], halted[8], program_counter[16:9],
                                  // accumulator_value[24:17], zero fill [31:25]
  output logic        out_tuser   // print_valid
);

  tac_pkg::cmd_t  cmd;
  tac_pkg::stat_t stat;
  logic           halted;
  logic [7:0]     print_value, program_counter, accumulator_value;

  tac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  tac_dpath #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .load_address      (in_tdata[7:0]),
    .load_data         (in_tdata[15:8]),
    .cmd               (cmd),
    .stat              (stat),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .print_valid       (out_tuser),
    .print_value       (print_value),
    .halted            (halted),
    .program_counter   (program_counter),
    .accumulator_value (accumulator_value)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {7'd0, accumulator_value, program_counter, halted, print_value};

endmodule

FILE: rtl/tac_ctrl.sv
// Controller of the tiny accumulator processor: one-hot state machine that
// sequences the memory accesses of one input item and the result hand-off.
// Depends on tac_pkg.
module tac_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           in_cmd,
  input  tac_pkg::stat_t stat,
  output tac_pkg::cmd_t  cmd
);

  tac_pkg::state_t state_r, state_nxt;
  logic            in_xfer;

  assign in_tready = (state_r == tac_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.addr_sel = tac_pkg::ASEL_PC;
    case (state_r)
      tac_pkg::ST_IDLE: begin
        // The opcode at PC is read every idle cycle so it is ready on a step.
        cmd.mem_rd = 1'b1;
        if (in_xfer) begin
          if (in_cmd == tac_pkg::CMD_LOAD) begin
            cmd.ld_wr = 1'b1;
            state_nxt = tac_pkg::ST_DONE;
          end else if (stat.halted) begin
            state_nxt = tac_pkg::ST_DONE;
          end else begin
            state_nxt = tac_pkg::ST_RD_ARG;
          end
        end
      end
      tac_pkg::ST_RD_ARG: begin
        cmd.cap_op   = 1'b1;
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = tac_pkg::ASEL_ARG;
        state_nxt    = tac_pkg::ST_RD_DATA;
      end
      tac_pkg::ST_RD_DATA: begin
        cmd.cap_arg  = 1'b1;
        cmd.addr_sel = tac_pkg::ASEL_OPND;
        if (stat.op_is_sta) begin
          cmd.sta_wr = 1'b1;
        end else begin
          cmd.mem_rd = 1'b1;
        end
        state_nxt = tac_pkg::ST_EXEC;
      end
      tac_pkg::ST_EXEC: begin
        if (stat.out_free) begin
          cmd.exec    = 1'b1;
          cmd.publish = 1'b1;
          state_nxt   = tac_pkg::ST_IDLE;
        end
      end
      tac_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = tac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tac_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tac_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/tac_dpath.sv
// Datapath of the tiny accumulator processor: unified memory, architectural
// registers, instruction execute logic and the result register.
// Depends on tac_pkg; driven by tac_ctrl.
module tac_dpath #(
  parameter int unsigned MEM_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     load_address,
  input  logic [7:0]     load_data,
  input  tac_pkg::cmd_t  cmd,
  output tac_pkg::stat_t stat,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic           print_valid,
  output logic [7:0]     print_value,
  output logic           halted,
  output logic [7:0]     program_counter,
  output logic [7:0]     accumulator_value
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  // Reduce an 8-bit address modulo MEM_DEPTH: for a MEM_DEPTH of 16 or more the
  // quotient is below 16, so four conditional subtract steps cover it.
  function automatic logic [AW-1:0] mem_index(input logic [7:0] addr);
    logic [11:0] rem;
    rem = {4'd0, addr};
    for (int k = 3; k >= 0; k--) begin
      if (rem >= (12'(MEM_DEPTH) << k)) begin
        rem = rem - (12'(MEM_DEPTH) << k);
      end
    end
    return rem[AW-1:0];
  endfunction

  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    mem_q;
  logic [7:0]    rd_addr;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] ld_idx;

  logic [7:0] acc_r, pc_r;
  logic       halt_r;
  logic [7:0] opcode_r, operand_r;
  logic [7:0] acc_nxt, pc_nxt;
  logic       halt_nxt;
  logic       prn_nxt;
  logic [7:0] prn_val_nxt;
  logic       out_valid_r;
  logic       out_prn_r;
  logic [7:0] out_prn_val_r, out_pc_r, out_acc_r;
  logic       out_halt_r;

  // Read address select; the operand byte is still on the read port in RD_DATA.
  always_comb begin
    case (cmd.addr_sel)
      tac_pkg::ASEL_PC:   rd_addr = pc_r;
      tac_pkg::ASEL_ARG:  rd_addr = pc_r + 8'd1;
      tac_pkg::ASEL_OPND: rd_addr = mem_q;
      default:            rd_addr = pc_r;
    endcase
  end

  assign rd_idx = mem_index(rd_addr);
  assign ld_idx = mem_index(load_address);

  // Memory write port: load items and STA.
  always_ff @(posedge clk) begin
    if (cmd.ld_wr) begin
      mem[ld_idx] <= load_data;
    end else if (cmd.sta_wr) begin
      mem[rd_idx] <= acc_r;
    end
  end

  // Memory read port with registered data.
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      mem_q <= mem[rd_idx];
    end
  end

  // Opcode and operand capture.
  always_ff @(posedge clk) begin
    if (cmd.cap_op) begin
      opcode_r <= mem_q;
    end
    if (cmd.cap_arg) begin
      operand_r <= mem_q;
    end
  end

  // Execute: mem_q holds the data byte at the operand address.
  always_comb begin
    acc_nxt     = acc_r;
    pc_nxt      = pc_r + tac_pkg::PC_STEP;
    halt_nxt    = halt_r;
    prn_nxt     = 1'b0;
    prn_val_nxt = 8'd0;
    case (opcode_r)
      tac_pkg::OP_LDA:   acc_nxt = mem_q;
      tac_pkg::OP_STA:   acc_nxt = acc_r;
      tac_pkg::OP_ADD:   acc_nxt = acc_r + mem_q;
      tac_pkg::OP_PRINT: begin
        prn_nxt     = 1'b1;
        prn_val_nxt = acc_r;
      end
      tac_pkg::OP_HALT:  halt_nxt = 1'b1;
      tac_pkg::OP_EQ:    acc_nxt = (acc_r == mem_q) ? 8'd1 : 8'd0;
      tac_pkg::OP_JMP:   pc_nxt = operand_r;
      tac_pkg::OP_JZ: begin
        if (acc_r == 8'd0) begin
          pc_nxt = operand_r;
        end
      end
      default: begin
        // Unknown opcode halts with PC left in place.
        halt_nxt = 1'b1;
        pc_nxt   = pc_r;
      end
    endcase
  end

  // Architectural registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= 8'd0;
      pc_r   <= 8'd0;
      halt_r <= 1'b0;
    end else if (cmd.exec) begin
      acc_r  <= acc_nxt;
      pc_r   <= pc_nxt;
      halt_r <= halt_nxt;
    end
  end

  // Result register: loaded on publish, emptied by an output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      if (cmd.exec) begin
        out_prn_r     <= prn_nxt;
        out_prn_val_r <= prn_val_nxt;
        out_halt_r    <= halt_nxt;
        out_pc_r      <= pc_nxt;
        out_acc_r     <= acc_nxt;
      end else begin
        out_prn_r     <= 1'b0;
        out_prn_val_r <= 8'd0;
        out_halt_r    <= halt_r;
        out_pc_r      <= pc_r;
        out_acc_r     <= acc_r;
      end
    end
  end

  assign stat.out_free  = !out_valid_r || out_tready;
  assign stat.halted    = halt_r;
  assign stat.op_is_sta = (opcode_r == tac_pkg::OP_STA);

  assign out_tvalid        = out_valid_r;
  assign print_valid       = out_prn_r;
  assign print_value       = out_prn_val_r;
  assign halted            = out_halt_r;
  assign program_counter   = out_pc_r;
  assign accumulator_value = out_acc_r;

endmodule

FILE: rtl/tac_checker.sv
// Port-level checker of the tiny accumulator processor, bound to the top
// level. Depends only on the ports of tiny_accumulator_cpu.
module tac_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Items are worked one at a time: no input transfer in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on consecutive cycles");

  // A printing instruction never leaves the machine halted.
  a_print_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[8])
    else $error("print result shows halted");

  // Print value is zero unless a print is reported.
  a_print_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'd0)
    else $error("print value nonzero without print");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind tiny_accumulator_cpu tac_checker u_tac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: bench/tb_tiny_accumulator_cpu.sv
// Self-checking bench for tiny_accumulator_cpu: directed programs, then random
// programs with memory loads mixed in, checked by an in-bench instruction predictor.
// Depends on tac_pkg and the tiny_accumulator_cpu RTL.
`timescale 1ns / 100ps

module tb_tiny_accumulator_cpu;

  // Item count at which the random part stops and the final halt is staged.
  localparam int RANDOM_END = 725;
  // Number of transfers sent after the machine has stopped.
  localparam int AFTER_HALT = 22;

  // Expected content of one result transfer.
  typedef struct packed {
    logic       print_valid;
    logic [7:0] print_value;
    logic       halted;
    logic [7:0] pc;
    logic [7:0] acc;
  } cpu_status_t;

  // Scoreboard: mirrors the processor state and queues the expected status.
  class cpu_scoreboard;
    logic [7:0]  mem [256];
    bit          written [256];
    logic [7:0]  acc;
    logic [7:0]  pc;
    bit          stopped;
    cpu_status_t status_q [$];
    int          errors;
    int          n_items;
    int          n_loads;
    int          n_steps;
    int          n_prints;
    int          n_idle_steps;
    int          n_results;

    function new();
      foreach (mem[i]) begin
        mem[i] = 8'd0;
        written[i] = 1'b0;
      end
      acc = 8'd0;
      pc = 8'd0;
      stopped = 1'b0;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH [%0t] %s", $time, msg);
    endtask

    // Applies one accepted input transfer and queues the status it must produce.
    function void predict_status(logic cmd, logic [7:0] addr, logic [7:0] data);
      cpu_status_t st;
      logic [7:0]  op;
      logic [7:0]  arg;
      logic [7:0]  arg_at;
      logic [7:0]  next_pc;
      st = '0;
      n_items++;
      if (cmd == tac_pkg::CMD_LOAD) begin
        // A load always writes memory, even after the machine has stopped.
        mem[addr] = data;
        written[addr] = 1'b1;
        n_loads++;
      end else if (stopped) begin
        n_idle_steps++;
      end else begin
        n_steps++;
        arg_at = pc + 8'd1;
        op = mem[pc];
        arg = mem[arg_at];
        next_pc = pc + tac_pkg::PC_STEP;
        case (op)
          tac_pkg::OP_LDA: acc = mem[arg];
          tac_pkg::OP_STA: begin
            mem[arg] = acc;
            written[arg] = 1'b1;
          end
          tac_pkg::OP_ADD: acc = acc + mem[arg];
          tac_pkg::OP_PRINT: begin
            st.print_valid = 1'b1;
            st.print_value = acc;
            n_prints++;
          end
          tac_pkg::OP_HALT: stopped = 1'b1;
          tac_pkg::OP_EQ: acc = (acc == mem[arg]) ? 8'd1 : 8'd0;
          tac_pkg::OP_JMP: next_pc = arg;
          tac_pkg::OP_JZ: begin
            if (acc == 8'd0) next_pc = arg;
          end
          default: begin
            // Unknown opcodes stop the machine and keep PC where it is.
            stopped = 1'b1;
            next_pc = pc;
          end
        endcase
        pc = next_pc;
      end
      st.halted = stopped;
      st.pc = pc;
      st.acc = acc;
      status_q.push_back(st);
    endfunction

    task compare(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d: %s is %0h, expected %0h", n_results, name, got, want));
    endtask

    // Compares one result transfer with the oldest expected status.
    task check_status(logic tuser, logic [31:0] tdata);
      cpu_status_t want;
      if (status_q.size() == 0) begin
        report($sformatf("result with nothing expected, tdata %h", tdata));
        return;
      end
      want = status_q.pop_front();
      n_results++;
      compare("print_valid", {7'd0, tuser}, {7'd0, want.print_valid});
      compare("print_value", tdata[7:0], want.print_value);
      compare("halted", {7'd0, tdata[8]}, {7'd0, want.halted});
      compare("program_counter", tdata[16:9], want.pc);
      compare("accumulator", tdata[24:17], want.acc);
      compare("zero fill", {1'b0, tdata[31:25]}, 8'd0);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;

  cpu_scoreboard cpu_model;
  bit            no_idle;
  int            stall_left;

  tiny_accumulator_cpu dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Result side: hold tready low for the drawn number of cycles.
  always @(negedge clk) begin
    out_tready <= (stall_left == 0);
    if (stall_left > 0) stall_left = stall_left - 1;
  end

  // Result monitor: check each transfer and draw the next stall.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      cpu_model.check_status(out_tuser, out_tdata);
      stall_left = no_idle ? 0 : int'($urandom_range(0, 12));
    end
  end

  // Sends one input transfer after a random gap and records it once accepted.
  task automatic send_item(logic cmd, logic [7:0] addr, logic [7:0] data);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(0, 12));
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {data, addr};
    do @(posedge clk); while (in_tready !== 1'b1);
    cpu_model.predict_status(cmd, addr, data);
  endtask

  // A step transfer; its address and data fields carry random filler.
  task automatic send_step();
    send_item(tac_pkg::CMD_STEP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Holds the input side idle until every expected result has been taken.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (cpu_model.status_q.size() != 0) @(posedge clk);
  endtask

  // Makes the instruction at PC runnable, loading new content where needed or at random, then executes it.
  // Every byte the instruction reads is written first.
  task automatic run_instruction();
    logic [7:0] at;
    logic [7:0] arg_at;
    logic [7:0] op;
    logic [7:0] arg;
    at = cpu_model.pc;
    arg_at = at + 8'd1;
    op = cpu_model.mem[at];
    if (!cpu_model.written[at] || op == tac_pkg::OP_HALT || op > tac_pkg::OP_JZ ||
        $urandom_range(0, 2) == 0) begin
      // Pick any opcode that keeps the machine running.
      op = 8'($urandom_range(0, 6));
      if (op >= tac_pkg::OP_HALT) op = op + 8'd1;
      send_item(tac_pkg::CMD_LOAD, at, op);
    end
    if (!cpu_model.written[arg_at] || $urandom_range(0, 3) == 0)
      send_item(tac_pkg::CMD_LOAD, arg_at, 8'($urandom_range(0, 255)));
    op = cpu_model.mem[at];
    arg = cpu_model.mem[arg_at];
    if (op == tac_pkg::OP_LDA || op == tac_pkg::OP_ADD || op == tac_pkg::OP_EQ) begin
      // For a compare, often plant the accumulator so that it matches.
      if (op == tac_pkg::OP_EQ && arg != at && arg != arg_at && $urandom_range(0, 1) == 0)
        send_item(tac_pkg::CMD_LOAD, arg, cpu_model.acc);
      else if (!cpu_model.written[arg])
        send_item(tac_pkg::CMD_LOAD, arg, 8'($urandom_range(0, 255)));
    end
    send_step();
  endtask

  // Main sequence: reset, directed program, random programs, final halt.
  initial begin
    logic [7:0] at;
    logic [7:0] stop_op;
    int         wait_cycles;
    cpu_model = new();
    no_idle = 1'b0;
    stall_left = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = tac_pkg::CMD_LOAD;
    out_tready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: byte extremes, wrapping add, both jump outcomes, PC wrap at 255.
    send_item(tac_pkg::CMD_LOAD, 8'd0, tac_pkg::OP_LDA);
    send_item(tac_pkg::CMD_LOAD, 8'd1, 8'd255);
    send_item(tac_pkg::CMD_LOAD, 8'd255, 8'd255);
    send_step();
    send_item(tac_pkg::CMD_LOAD, 8'd2, tac_pkg::OP_ADD);
    send_item(tac_pkg::CMD_LOAD, 8'd3, 8'd128);
    send_item(tac_pkg::CMD_LOAD, 8'd128, 8'd1);
    send_step();
    // The accumulator wrapped to zero, so this conditional jump is taken.
    send_item(tac_pkg::CMD_LOAD, 8'd4, tac_pkg::OP_JZ);
    send_item(tac_pkg::CMD_LOAD, 8'd5, 8'd254);
    send_step();
    // Print at the top of memory; the operand sits at 255 and PC wraps to 0.
    send_item(tac_pkg::CMD_LOAD, 8'd254, tac_pkg::OP_PRINT);
    send_step();
    send_item(tac_pkg::CMD_LOAD, 8'd0, tac_pkg::OP_EQ);
    send_step();
    send_item(tac_pkg::CMD_LOAD, 8'd2, tac_pkg::OP_STA);
    send_step();
    // The stored zero now matches the accumulator.
    send_item(tac_pkg::CMD_LOAD, 8'd4, tac_pkg::OP_EQ);
    send_item(tac_pkg::CMD_LOAD, 8'd5, 8'd128);
    send_step();
    send_item(tac_pkg::CMD_LOAD, 8'd6, tac_pkg::OP_JZ);
    send_item(tac_pkg::CMD_LOAD, 8'd7, 8'd0);
    send_step();
    send_item(tac_pkg::CMD_LOAD, 8'd8, tac_pkg::OP_JMP);
    send_item(tac_pkg::CMD_LOAD, 8'd9, 8'd254);
    send_step();
    send_step();
    drain_results();

    // Random programs, with stray loads and bursts without idle cycles.
    while (cpu_model.n_items < RANDOM_END) begin
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      if ($urandom_range(0, 149) == 0) drain_results();
      if ($urandom_range(0, 4) == 0)
        send_item(tac_pkg::CMD_LOAD, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      else
        run_instruction();
    end

    // Stop the machine with either HALT or an undefined opcode, then keep
    // sending loads and steps that must leave the state alone.
    no_idle = 1'b0;
    at = cpu_model.pc;
    if (!cpu_model.written[at + 8'd1])
      send_item(tac_pkg::CMD_LOAD, at + 8'd1, 8'($urandom_range(0, 255)));
    stop_op = ($urandom_range(0, 1) == 0) ?
              tac_pkg::OP_HALT : 8'($urandom_range(int'(tac_pkg::OP_JZ) + 1, 255));
    send_item(tac_pkg::CMD_LOAD, at, stop_op);
    send_step();
    repeat (AFTER_HALT) begin
      if ($urandom_range(0, 1) == 0)
        send_step();
      else
        send_item(tac_pkg::CMD_LOAD, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    end

    // Wait for the remaining results, then a few more cycles for strays.
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (cpu_model.status_q.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (16) @(posedge clk);
    if (cpu_model.status_q.size() != 0)
      cpu_model.report($sformatf("%0d results never arrived", cpu_model.status_q.size()));

    $display("Run covered %0d loads, %0d executed instructions with %0d prints,",
             cpu_model.n_loads, cpu_model.n_steps, cpu_model.n_prints);
    $display("a stop on opcode %0d, %0d steps while stopped and %0d checked results.",
             stop_op, cpu_model.n_idle_steps, cpu_model.n_results);
    if (cpu_model.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tac_pkg.sv
rtl/tac_ctrl.sv
rtl/tac_dpath.sv
rtl/tiny_accumulator_cpu.sv
rtl/tac_checker.sv
bench/tb_tiny_accumulator_cpu.sv
